/* rtl/core/vpv_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpv_pkg
// Shared types, constants and helpers of the vertex viewport projector.
// ----------------------------------------------------------------------------
package vpv_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned CoefW    = 16;
  localparam int unsigned RowW     = 64;
  localparam int unsigned CanvasW  = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned ProdW    = CoordW + CoefW;   // 48
  localparam int unsigned DotW     = ProdW + 2;        // 50
  localparam int unsigned QuotW    = 32;
  localparam int unsigned DivStages = 16;
  localparam int unsigned StepsPerStage = QuotW / DivStages;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegRow0   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegRow1   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegRow2   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRow3   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegWidth  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegHeight = 3'd5;

  localparam logic [RowW-1:0] Row0Reset = 64'd1024;
  localparam logic [RowW-1:0] Row1Reset = 64'd1024 << 16;
  localparam logic [RowW-1:0] Row2Reset = 64'd1024 << 32;
  localparam logic [RowW-1:0] Row3Reset = 64'd1024 << 48;
  localparam logic [CanvasW-1:0] WidthReset  = 16'd640;
  localparam logic [CanvasW-1:0] HeightReset = 16'd480;

  localparam logic signed [32:0] OneQ16 = 33'sd65536;
  localparam logic signed [32:0] EpsQ16 = 33'sd66;

  // divider lane state, three numerators over one denominator
  typedef struct packed {
    logic [2:0][DotW-1:0]  rem;
    logic [2:0][QuotW-1:0] nb;
    logic [2:0][QuotW-1:0] q;
    logic [2:0]            neg;
    logic [2:0]            sat;
    logic [DotW-1:0]       ud;
    logic                  wz;
  } div_t;

  function automatic logic signed [31:0] sat32(input logic signed [DotW-1:0] v);
    logic signed [DotW-1:0] hi;
    logic signed [DotW-1:0] lo;
    hi = DotW'(64'sh7FFF_FFFF);
    lo = -DotW'(64'sh8000_0000);
    if (v > hi) return 32'sh7FFF_FFFF;
    if (v < lo) return 32'sh8000_0000;
    return v[31:0];
  endfunction

endpackage

/* rtl/core/vpv_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpv interfaces
// Point, screen and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface vpv_point_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface vpv_screen_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] screen_x;
  logic signed [31:0] screen_y;
  logic signed [31:0] depth;
  logic               w_zero;
  modport source (output valid, screen_x, screen_y, depth, w_zero, input ready);
  modport sink   (input valid, screen_x, screen_y, depth, w_zero, output ready);
endinterface

interface vpv_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/vpv_div_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpv_div_stage
// One registered stage of the restoring divider: two quotient bits per lane.
// ----------------------------------------------------------------------------
module vpv_div_stage (
  input  logic          clk_i,
  input  logic          en_i,
  input  vpv_pkg::div_t div_i,
  output vpv_pkg::div_t div_o
);

  vpv_pkg::div_t div_d;
  vpv_pkg::div_t div_q;

  always_comb begin
    logic [vpv_pkg::DotW:0] trial;
    div_d = div_i;
    trial = '0;
    for (int l = 0; l < 3; l++) begin
      for (int s = 0; s < vpv_pkg::StepsPerStage; s++) begin
        // shift in next numerator bit, subtract when it fits
        trial = {div_d.rem[l], div_d.nb[l][vpv_pkg::QuotW-1]};
        div_d.nb[l] = {div_d.nb[l][vpv_pkg::QuotW-2:0], 1'b0};
        if (trial >= {1'b0, div_d.ud}) begin
          trial = trial - {1'b0, div_d.ud};
          div_d.q[l] = {div_d.q[l][vpv_pkg::QuotW-2:0], 1'b1};
        end else begin
          div_d.q[l] = {div_d.q[l][vpv_pkg::QuotW-2:0], 1'b0};
        end
        div_d.rem[l] = trial[vpv_pkg::DotW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign div_o = div_q;

endmodule

/* rtl/core/vertex_project_to_viewport.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_project_to_viewport
// Matrix transform, perspective divide and viewport map of Q16.16 points.
// ----------------------------------------------------------------------------
// Takes one point per cycle while the output is not stalled and returns one
// screen result per point: two stages for the 4x4 matrix product, two for sign
// handling and overflow check, sixteen for the restoring divider (two
// quotient bits per stage, three lanes sharing the w denominator), and three
// for the viewport scale, halving and saturation. Every stage holds its own
// valid bit, so a stalled output only stops the stages that are full.
// Configuration writes are taken in any cycle and must arrive while idle.
module vertex_project_to_viewport (
  input  logic                clk_i,
  input  logic                rst_ni,
  vpv_cfg_if.sink             cfg_i,
  vpv_point_if.sink           point_i,
  vpv_screen_if.source        screen_o
);

  localparam int unsigned NStages = 7 + vpv_pkg::DivStages;
  localparam int unsigned DivFirst = 4;
  localparam int unsigned DivLast  = DivFirst + vpv_pkg::DivStages - 1;

  // configuration registers
  logic [3:0][vpv_pkg::RowW-1:0] row_q;
  logic [vpv_pkg::CanvasW-1:0]   width_q;
  logic [vpv_pkg::CanvasW-1:0]   height_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0] <= vpv_pkg::Row0Reset;
      row_q[1] <= vpv_pkg::Row1Reset;
      row_q[2] <= vpv_pkg::Row2Reset;
      row_q[3] <= vpv_pkg::Row3Reset;
      width_q  <= vpv_pkg::WidthReset;
      height_q <= vpv_pkg::HeightReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        vpv_pkg::RegRow0:   row_q[0] <= cfg_i.data;
        vpv_pkg::RegRow1:   row_q[1] <= cfg_i.data;
        vpv_pkg::RegRow2:   row_q[2] <= cfg_i.data;
        vpv_pkg::RegRow3:   row_q[3] <= cfg_i.data;
        vpv_pkg::RegWidth:  width_q  <= cfg_i.data[vpv_pkg::CanvasW-1:0];
        vpv_pkg::RegHeight: height_q <= cfg_i.data[vpv_pkg::CanvasW-1:0];
        default: ;
      endcase
    end
  end

  // per-stage valid and advance
  logic [NStages-1:0] vld_q;
  logic [NStages:0]   adv;

  always_comb begin
    adv[NStages] = screen_o.ready;
    for (int k = NStages - 1; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign point_i.ready = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= point_i.valid;
      end
      for (int k = 1; k < NStages; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // stage 0: products
  logic signed [3:0][3:0][vpv_pkg::ProdW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      for (int r = 0; r < 4; r++) begin
        prod_q[r][0] <= $signed(row_q[r][15:0])  * point_i.point_x;
        prod_q[r][1] <= $signed(row_q[r][31:16]) * point_i.point_y;
        prod_q[r][2] <= $signed(row_q[r][47:32]) * point_i.point_z;
        prod_q[r][3] <= {{16{row_q[r][63]}}, row_q[r][63:48], 16'b0};
      end
    end
  end

  // stage 1: row sums
  logic signed [3:0][vpv_pkg::DotW-1:0] dot_q;

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      for (int r = 0; r < 4; r++) begin
        dot_q[r] <= vpv_pkg::DotW'($signed(prod_q[r][0])) +
                    vpv_pkg::DotW'($signed(prod_q[r][1])) +
                    vpv_pkg::DotW'($signed(prod_q[r][2])) +
                    vpv_pkg::DotW'($signed(prod_q[r][3]));
      end
    end
  end

  // stage 2: magnitudes and signs
  logic [2:0][vpv_pkg::DotW-1:0] un_q;
  logic [vpv_pkg::DotW-1:0]      ud_q;
  logic [2:0]                    neg_q;
  logic                          wz2_q;

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      for (int l = 0; l < 3; l++) begin
        un_q[l]  <= dot_q[l][vpv_pkg::DotW-1] ? -dot_q[l] : dot_q[l];
        neg_q[l] <= dot_q[l][vpv_pkg::DotW-1] ^ dot_q[3][vpv_pkg::DotW-1];
      end
      ud_q  <= dot_q[3][vpv_pkg::DotW-1] ? -dot_q[3] : dot_q[3];
      wz2_q <= (dot_q[3] == '0);
    end
  end

  // stage 3: overflow check and divider setup
  vpv_pkg::div_t div_q [DivFirst-1:DivLast];

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      for (int l = 0; l < 3; l++) begin
        div_q[DivFirst-1].sat[l] <= {15'b0, un_q[l]} >= {ud_q, 15'b0};
        div_q[DivFirst-1].rem[l] <= {16'b0, un_q[l][vpv_pkg::DotW-1:16]};
        div_q[DivFirst-1].nb[l]  <= {un_q[l][15:0], 16'b0};
        div_q[DivFirst-1].q[l]   <= '0;
      end
      div_q[DivFirst-1].neg <= neg_q;
      div_q[DivFirst-1].ud  <= ud_q;
      div_q[DivFirst-1].wz  <= wz2_q;
    end
  end

  for (genvar g = DivFirst; g <= DivLast; g++) begin : g_div
    vpv_div_stage u_div (
      .clk_i (clk_i),
      .en_i  (adv[g]),
      .div_i (div_q[g-1]),
      .div_o (div_q[g])
    );
  end

  // stage 20: ratio with saturation, then offset by one
  logic signed [2:0][32:0] s_q;
  logic                    wz20_q;

  always_ff @(posedge clk_i) begin
    logic signed [31:0] r;
    if (adv[DivLast+1]) begin
      for (int l = 0; l < 3; l++) begin
        if (div_q[DivLast].sat[l]) begin
          r = div_q[DivLast].neg[l] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
          r = div_q[DivLast].neg[l] ? -$signed(div_q[DivLast].q[l])
                                    : $signed(div_q[DivLast].q[l]);
        end
        s_q[l] <= 33'(r) + vpv_pkg::OneQ16;
      end
      wz20_q <= div_q[DivLast].wz;
    end
  end

  // stage 21: canvas scale and depth
  logic signed [vpv_pkg::DotW-1:0] px_q;
  logic signed [vpv_pkg::DotW-1:0] py_q;
  logic signed [31:0]              dz_q;
  logic                            wz21_q;

  always_ff @(posedge clk_i) begin
    logic signed [32:0] half;
    if (adv[DivLast+2]) begin
      px_q <= vpv_pkg::DotW'($signed(s_q[0])) * vpv_pkg::DotW'($signed({1'b0, width_q}));
      py_q <= vpv_pkg::DotW'($signed(s_q[1])) * vpv_pkg::DotW'($signed({1'b0, height_q}));
      half = ($signed(s_q[2]) + $signed(33'(s_q[2][32]))) >>> 1;
      dz_q <= vpv_pkg::sat32(vpv_pkg::DotW'(half - vpv_pkg::EpsQ16));
      wz21_q <= wz20_q;
    end
  end

  // stage 22: halve toward zero, saturate, output register
  logic signed [31:0] sx_q;
  logic signed [31:0] sy_q;
  logic signed [31:0] dout_q;
  logic               wz22_q;

  always_ff @(posedge clk_i) begin
    logic signed [vpv_pkg::DotW-1:0] hx;
    logic signed [vpv_pkg::DotW-1:0] hy;
    if (adv[DivLast+3]) begin
      hx = (px_q + $signed(vpv_pkg::DotW'(px_q[vpv_pkg::DotW-1]))) >>> 1;
      hy = (py_q + $signed(vpv_pkg::DotW'(py_q[vpv_pkg::DotW-1]))) >>> 1;
      sx_q   <= wz21_q ? '0 : vpv_pkg::sat32(hx);
      sy_q   <= wz21_q ? '0 : vpv_pkg::sat32(hy);
      dout_q <= wz21_q ? '0 : dz_q;
      wz22_q <= wz21_q;
    end
  end

  assign screen_o.valid    = vld_q[NStages-1];
  assign screen_o.screen_x = sx_q;
  assign screen_o.screen_y = sy_q;
  assign screen_o.depth    = dout_q;
  assign screen_o.w_zero   = wz22_q;

endmodule

/* sim/vpv_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpv_checker
// Watches the configuration, point and screen channels. Keeps its own copy of
// the matrix and canvas registers, predicts each screen result and compares
// it field by field with what the projector returns.
// ----------------------------------------------------------------------------
module vpv_checker (
  input  logic clk_i,
  input  logic rst_ni,
  vpv_cfg_if    cfg,
  vpv_point_if  pt,
  vpv_screen_if scr,
  output int    errors_o,
  output int    pending_o,
  output int    checked_o,
  output int    wzero_seen_o
);

  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] dz;
    logic               wz;
  } screen_t;

  logic [vpv_pkg::RowW-1:0]    mtx [4];
  logic [vpv_pkg::CanvasW-1:0] cw;
  logic [vpv_pkg::CanvasW-1:0] ch;
  screen_t                     expected_q[$];

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // truncated Q16.16 quotient, saturated once the integer part reaches 32768
  function automatic longint div_q16(longint n, longint d);
    logic [127:0] un;
    logic [127:0] ud;
    logic [127:0] mag;
    logic         neg;
    neg = (n < 0) != (d < 0);
    un  = (n < 0) ? 128'(-n) : 128'(n);
    ud  = (d < 0) ? 128'(-d) : 128'(d);
    if (un / ud >= 128'd32768) return neg ? -64'sd2147483648 : 64'sd2147483647;
    mag = (un << 16) / ud;
    return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
  endfunction

  function automatic screen_t project(logic signed [31:0] px, logic signed [31:0] py,
                                      logic signed [31:0] pz);
    longint  p [4];
    longint  t [4];
    longint  s0, s1, s2;
    screen_t r;
    p[0] = px;
    p[1] = py;
    p[2] = pz;
    p[3] = 65536;
    for (int i = 0; i < 4; i++) begin
      t[i] = 0;
      for (int j = 0; j < 4; j++) begin
        t[i] += longint'($signed(mtx[i][16*j +: 16])) * p[j];
      end
    end
    if (t[3] == 0) begin
      r = '{sx: '0, sy: '0, dz: '0, wz: 1'b1};
      return r;
    end
    s0 = div_q16(t[0], t[3]) + 65536;
    s1 = div_q16(t[1], t[3]) + 65536;
    s2 = div_q16(t[2], t[3]) + 65536;
    r.sx = 32'(clip32((s0 * longint'(cw)) / 2));
    r.sy = 32'(clip32((s1 * longint'(ch)) / 2));
    r.dz = 32'(clip32(s2 / 2 - 66));
    r.wz = 1'b0;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    screen_t e;
    if (!rst_ni) begin
      mtx[0] = vpv_pkg::Row0Reset;
      mtx[1] = vpv_pkg::Row1Reset;
      mtx[2] = vpv_pkg::Row2Reset;
      mtx[3] = vpv_pkg::Row3Reset;
      cw = vpv_pkg::WidthReset;
      ch = vpv_pkg::HeightReset;
      expected_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          vpv_pkg::RegRow0:   mtx[0] = cfg.data;
          vpv_pkg::RegRow1:   mtx[1] = cfg.data;
          vpv_pkg::RegRow2:   mtx[2] = cfg.data;
          vpv_pkg::RegRow3:   mtx[3] = cfg.data;
          vpv_pkg::RegWidth:  cw = cfg.data[vpv_pkg::CanvasW-1:0];
          vpv_pkg::RegHeight: ch = cfg.data[vpv_pkg::CanvasW-1:0];
          default: ;
        endcase
      end
      if (scr.valid && scr.ready) begin
        if (expected_q.size() == 0) begin
          errors_o++;
          $display("%0t: unexpected screen result x=%h y=%h d=%h wz=%b", $time,
                   scr.screen_x, scr.screen_y, scr.depth, scr.w_zero);
        end else begin
          e = expected_q.pop_front();
          checked_o++;
          if (e.wz) wzero_seen_o++;
          if (scr.screen_x !== e.sx) begin
            errors_o++;
            $display("%0t: screen_x expected %h actual %h", $time, e.sx, scr.screen_x);
          end
          if (scr.screen_y !== e.sy) begin
            errors_o++;
            $display("%0t: screen_y expected %h actual %h", $time, e.sy, scr.screen_y);
          end
          if (scr.depth !== e.dz) begin
            errors_o++;
            $display("%0t: depth expected %h actual %h", $time, e.dz, scr.depth);
          end
          if (scr.w_zero !== e.wz) begin
            errors_o++;
            $display("%0t: w_zero expected %b actual %b", $time, e.wz, scr.w_zero);
          end
        end
      end
      if (pt.valid && pt.ready) expected_q.push_back(project(pt.point_x, pt.point_y, pt.point_z));
    end
    pending_o = expected_q.size();
  end

  initial begin
    errors_o     = 0;
    pending_o    = 0;
    checked_o    = 0;
    wzero_seen_o = 0;
  end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the vertex viewport projector with directed and random points under
// a series of matrix and canvas settings, with bursty requests and a stalling
// receiver; the checker predicts and compares every screen result.
// ----------------------------------------------------------------------------
module tb_top;

  logic clk_i;
  logic rst_ni;
  int   errors, pending, checked, wzero_seen;
  int   burst_left;
  int   n_cfg;
  bit   hold_req;
  int   stall_pct;

  vpv_cfg_if    cfg ();
  vpv_point_if  pt ();
  vpv_screen_if scr ();

  vertex_project_to_viewport dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .point_i  (pt),
    .screen_o (scr)
  );

  vpv_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg          (cfg),
    .pt           (pt),
    .scr          (scr),
    .errors_o     (errors),
    .pending_o    (pending),
    .checked_o    (checked),
    .wzero_seen_o (wzero_seen)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin
    #10ms;
    $display("DONE: errors detected");
    $finish;
  end

  // receiver: random stall rate that changes now and then, plus a long hold-off on request
  initial begin
    int cnt;
    scr.ready = 1'b0;
    stall_pct = 0;
    cnt = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        scr.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        if (cnt == 0) begin
          cnt = $urandom_range(50, 300);
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 20;
            2: stall_pct = 50;
            default: stall_pct = 85;
          endcase
        end
        cnt--;
        scr.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  function automatic logic [vpv_pkg::RowW-1:0] pack_row(logic [15:0] c0, logic [15:0] c1,
                                                        logic [15:0] c2, logic [15:0] c3);
    return {c3, c2, c1, c0};
  endfunction

  task automatic write_reg(logic [vpv_pkg::CfgIdxW-1:0] idx, logic [63:0] value);
    bit rdy;
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do begin
      @(negedge clk_i);
      rdy = cfg.ready;
      @(posedge clk_i);
    end while (!rdy);
    cfg.valid <= 1'b0;
    n_cfg++;
    @(posedge clk_i);
  endtask

  // sender: bursts of requests with random gaps between them
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    bit rdy;
    pt.valid   <= 1'b1;
    pt.point_x <= x;
    pt.point_y <= y;
    pt.point_z <= z;
    do begin
      @(negedge clk_i);
      rdy = pt.ready;
      @(posedge clk_i);
    end while (!rdy);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      pt.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    pt.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2 * 262144)) - 262144);
      2: return 32'($signed($urandom_range(0, 2 * 65536)) - 65536);
      default: return 32'($signed($urandom_range(0, 2 * 4096)) - 4096);
    endcase
  endfunction

  function automatic logic [15:0] rand_coef();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 16'($signed($urandom_range(0, 4096)) - 2048);
      default: return 16'($signed($urandom_range(0, 512)) - 256);
    endcase
  endfunction

  task automatic random_config();
    logic [15:0] w3;
    for (int i = 0; i < 3; i++) begin
      write_reg(vpv_pkg::CfgIdxW'(i),
                pack_row(rand_coef(), rand_coef(), rand_coef(), rand_coef()));
    end
    // keep w mostly away from zero, but allow a column-3-free w row for zero w
    if ($urandom_range(0, 3) == 0) w3 = 16'h0000;
    else w3 = 16'($urandom_range(256, 2048));
    write_reg(vpv_pkg::RegRow3,
              pack_row(rand_coef() >>> 4, rand_coef() >>> 4, rand_coef() >>> 4, w3));
    case ($urandom_range(0, 4))
      0: write_reg(vpv_pkg::RegWidth, 64'd1);
      1: write_reg(vpv_pkg::RegWidth, 64'd65535);
      2: write_reg(vpv_pkg::RegWidth, 64'd0);
      default: write_reg(vpv_pkg::RegWidth, 64'($urandom_range(1, 4096)));
    endcase
    case ($urandom_range(0, 4))
      0: write_reg(vpv_pkg::RegHeight, 64'd1);
      1: write_reg(vpv_pkg::RegHeight, 64'd65535);
      2: write_reg(vpv_pkg::RegHeight, 64'd0);
      default: write_reg(vpv_pkg::RegHeight, 64'($urandom_range(1, 4096)));
    endcase
  endtask

  initial begin
    rst_ni     = 1'b0;
    hold_req   = 1'b0;
    burst_left = 0;
    n_cfg      = 0;
    cfg.valid  = 1'b0;
    cfg.index  = '0;
    cfg.data   = '0;
    pt.valid   = 1'b0;
    pt.point_x = '0;
    pt.point_y = '0;
    pt.point_z = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset matrix and canvas
    send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000);
    send_point(32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_8000);
    drain();

    // w taken from x alone: zero w, tiny w and negative w
    write_reg(vpv_pkg::RegRow3, pack_row(16'd1024, 16'd0, 16'd0, 16'd0));
    write_reg(vpv_pkg::RegRow0, pack_row(16'd0, 16'd0, 16'd0, 16'h7FFF));
    write_reg(vpv_pkg::RegRow1, pack_row(16'd0, 16'd0, 16'd0, 16'h8000));
    write_reg(vpv_pkg::RegRow2, pack_row(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF));
    write_reg(vpv_pkg::RegWidth, 64'd65535);
    write_reg(vpv_pkg::RegHeight, 64'd0);
    write_reg(3'd6, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(3'd7, 64'h0);
    drain();
    send_point(32'h0000_0000, 32'h1234_5678, 32'h8000_0000);
    send_point(32'h0000_0001, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000);
    send_point(32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send_point(32'hFFFF_0000, 32'h0000_0001, 32'hFFFF_FFFF);
    drain();

    write_reg(vpv_pkg::RegRow0, vpv_pkg::Row0Reset);
    write_reg(vpv_pkg::RegRow1, vpv_pkg::Row1Reset);
    write_reg(vpv_pkg::RegRow2, vpv_pkg::Row2Reset);
    write_reg(vpv_pkg::RegRow3, vpv_pkg::Row3Reset);
    write_reg(vpv_pkg::RegWidth, 64'd1);
    write_reg(vpv_pkg::RegHeight, 64'd65535);
    drain();
    send_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send_point(32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000);
    send_point(32'h7FFF_0000, 32'h8000_0000, 32'h0000_0000);
    send_point(32'h0000_8000, 32'hFFFF_8000, 32'h7FFF_FFFF);
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      random_config();
      drain();
      if (ph == 2) hold_req = 1'b1;
      repeat (225) send_point(rand_coord(), rand_coord(), rand_coord());
      drain();
    end

    $display("covered %0d screen results (%0d with zero w) over %0d register writes",
             checked, wzero_seen, n_cfg);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
